### src/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

    // request codes
    typedef enum logic [2:0] {
        F_PUSH_FRONT = 3'd0,
        F_PUSH_BACK  = 3'd1,
        F_POP_FRONT  = 3'd2,
        F_POP_BACK   = 3'd3,
        F_DUMP       = 3'd4
    } t_func;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_stat;

    // input word
    typedef struct packed {
        t_func              func;
        logic signed [31:0] value;
    } t_req;

    // output word
    typedef struct packed {
        t_stat              status;
        logic signed [31:0] item;
        logic               last;
    } t_rsp;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_OUT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic  take_req;
        logic  push_wr;
        logic  pop_rd;
        logic  dump_start;
        logic  dump_next;
        logic  load_mem;
        logic  load_st;
        t_stat st_code;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_func func;
        logic  empty;
        logic  full;
        logic  dump_last;
    } t_sts;

endpackage

### src/deq_ctrl.sv
`timescale 1ns / 1ps

module deq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  deq_pkg::t_sts i_sts,
    output deq_pkg::t_cmd o_cmd
);
    import deq_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.func)
                    F_PUSH_FRONT, F_PUSH_BACK: n_state = S_OUT;
                    F_POP_FRONT, F_POP_BACK, F_DUMP: begin
                        n_state = i_sts.empty ? S_OUT : S_READ;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    if (i_sts.func == F_DUMP && !i_sts.empty && !i_sts.dump_last) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        o_cmd   = '0;
        o_cmd.st_code = ST_OK;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready        = 1'b1;
                o_cmd.take_req = i_valid;
            end
            S_EXEC: begin
                case (i_sts.func)
                    F_PUSH_FRONT, F_PUSH_BACK: begin
                        o_cmd.load_st = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.st_code = ST_FULL;
                        end else begin
                            o_cmd.push_wr = 1'b1;
                        end
                    end
                    F_POP_FRONT, F_POP_BACK: begin
                        if (i_sts.empty) begin
                            o_cmd.load_st = 1'b1;
                            o_cmd.st_code = ST_EMPTY;
                        end else begin
                            o_cmd.pop_rd = 1'b1;
                        end
                    end
                    F_DUMP: begin
                        if (i_sts.empty) begin
                            o_cmd.load_st = 1'b1;
                            o_cmd.st_code = ST_EMPTY;
                        end else begin
                            o_cmd.dump_start = 1'b1;
                        end
                    end
                    default: o_cmd.st_code = ST_OK;
                endcase
            end
            S_READ: begin
                o_cmd.load_mem = 1'b1;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready && i_sts.func == F_DUMP && !i_sts.empty && !i_sts.dump_last) begin
                    o_cmd.dump_next = 1'b1;
                end
            end
            default: o_valid = 1'b0;
        endcase
    end

endmodule

### src/deq_dpath.sv
`timescale 1ns / 1ps

module deq_dpath #(
    parameter int DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  deq_pkg::t_req i_req,
    input  deq_pkg::t_cmd i_cmd,
    output deq_pkg::t_sts o_sts,
    output deq_pkg::t_rsp o_rsp
);
    import deq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = $clog2(DEPTH + 1);
    localparam int SW = OW + 1;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;
    t_req               r_req;
    t_rsp               r_rsp;
    logic [PW-1:0]      r_front;
    logic [OW-1:0]      r_occ;
    logic [OW-1:0]      r_cnt;
    logic [PW-1:0]      n_front;
    logic [OW-1:0]      n_occ;
    logic [PW-1:0]      wr_addr;
    logic [PW-1:0]      rd_addr;
    logic               dump_last;

    // front pointer plus offset, wrapped into the ring
    function automatic logic [PW-1:0] ring(input logic [PW-1:0] base,
                                           input logic [OW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    assign dump_last = ((r_cnt + OW'(1)) == r_occ);

    // status to controller
    assign o_sts.func      = r_req.func;
    assign o_sts.empty     = (r_occ == '0);
    assign o_sts.full      = (r_occ == OW'(DEPTH));
    assign o_sts.dump_last = dump_last;

    // write address and pointer update for pushes and pops
    always_comb begin
        n_front = r_front;
        n_occ   = r_occ;
        wr_addr = ring(r_front, r_occ);
        if (r_front == '0) begin
            wr_addr = PW'(DEPTH - 1);
        end else begin
            wr_addr = r_front - PW'(1);
        end
        if (r_req.func == F_PUSH_BACK) begin
            wr_addr = ring(r_front, r_occ);
        end
        if (i_cmd.push_wr) begin
            n_occ = r_occ + OW'(1);
            if (r_req.func == F_PUSH_FRONT) begin
                n_front = wr_addr;
            end
        end else if (i_cmd.pop_rd) begin
            n_occ = r_occ - OW'(1);
            if (r_req.func == F_POP_FRONT) begin
                if (r_front == PW'(DEPTH - 1)) begin
                    n_front = '0;
                end else begin
                    n_front = r_front + PW'(1);
                end
            end
        end
    end

    // read address for pops and dump steps
    always_comb begin
        rd_addr = r_front;
        if (i_cmd.pop_rd) begin
            if (r_req.func == F_POP_BACK) begin
                rd_addr = ring(r_front, r_occ - OW'(1));
            end
        end else if (i_cmd.dump_next) begin
            rd_addr = ring(r_front, r_cnt + OW'(1));
        end
    end

    // pointers and dump counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_occ   <= '0;
            r_cnt   <= '0;
        end else begin
            r_front <= n_front;
            r_occ   <= n_occ;
            if (i_cmd.dump_start) begin
                r_cnt <= '0;
            end else if (i_cmd.dump_next) begin
                r_cnt <= r_cnt + OW'(1);
            end
        end
    end

    // ring storage with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            r_mem[wr_addr] <= r_req.value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // request capture and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_req <= i_req;
        end
        if (i_cmd.load_st) begin
            r_rsp.status <= i_cmd.st_code;
            r_rsp.item   <= '0;
            r_rsp.last   <= 1'b1;
        end else if (i_cmd.load_mem) begin
            r_rsp.status <= ST_OK;
            r_rsp.item   <= r_rdata;
            r_rsp.last   <= (r_req.func == F_DUMP) ? dump_last : 1'b1;
        end
    end

    assign o_rsp = r_rsp;

endmodule

### src/double_ended_queue_core.sv
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit words in a ring of DEPTH entries. Each
// request pushes at the front or back, pops from the front or back, or dumps
// the queue from front to back; every request answers with one word carrying
// a status, except a dump of a non-empty queue, which gives one word per entry
// with last set on the final one. Unused function codes are taken and give no
// word. One request is handled at a time. A push passes through the idle,
// execute and output states; a pop, or a dump of a non-empty queue, adds a
// read state before each output word, since the storage's read data is
// registered, and an empty pop or dump goes from execute straight to output.
// Storage needs no clearing after reset.
module double_ended_queue_core #(
    parameter int DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  deq_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output deq_pkg::t_rsp o_rsp
);
    import deq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing
    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // storage, pointers and output word
    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule
